// File: design/mfld_pkg.sv
// ----------------------------------------------------------------------------
// mfld_pkg
// Shared widths, codes, types and helpers for the mono framebuffer line drawer.
// ----------------------------------------------------------------------------
package mfld_pkg;

  localparam int CMD_W      = 2;
  localparam int X_W        = 7;
  localparam int Y_W        = 6;
  localparam int BIDX_W     = 10;
  localparam int DATA_W     = 8;
  localparam int PW_W       = 8;
  localparam int PH_W       = 7;
  localparam int PAGE_BITS  = 3;
  localparam int PIX_ADDR_W = 12;
  localparam int ERR_W      = 10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  localparam logic [PW_W-1:0] PANEL_WIDTH_RESET  = 8'd128;
  localparam logic [PH_W-1:0] PANEL_HEIGHT_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

  localparam logic [DATA_W-1:0] BYTE_ONES  = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_ZEROS = 8'h00;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_DRAW_LINE = 2'd0,
    CMD_FILL      = 2'd1,
    CMD_READ_BYTE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE,
    ST_DRAIN,
    ST_FILL,
    ST_RD_WAIT,
    ST_RESP
  } state_t;

  // Byte address of pixel (x, y) in page layout.
  function automatic logic [PIX_ADDR_W-1:0] pix_addr(input logic [X_W-1:0]  x,
                                                     input logic [Y_W-1:0]  y,
                                                     input logic [PW_W-1:0] w);
    logic [PIX_ADDR_W-1:0] row_base;
    row_base = PIX_ADDR_W'(y[Y_W-1:PAGE_BITS]) * PIX_ADDR_W'(w);
    return row_base + PIX_ADDR_W'(x);
  endfunction

  function automatic logic [DATA_W-1:0] pix_mask(input logic [Y_W-1:0] y);
    return DATA_W'(1) << y[PAGE_BITS-1:0];
  endfunction

endpackage

// File: design/mfld_in_if.sv
// ----------------------------------------------------------------------------
// mfld_in_if
// Command request channel: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface mfld_in_if import mfld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [X_W-1:0]    x_start;
  logic [Y_W-1:0]    y_start;
  logic [X_W-1:0]    x_end;
  logic [Y_W-1:0]    y_end;
  logic              pixel_on;
  logic [BIDX_W-1:0] byte_index;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, pixel_on, byte_index,
    input  ready
  );
  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, pixel_on, byte_index,
    output ready
  );
endinterface

// File: design/mfld_out_if.sv
// ----------------------------------------------------------------------------
// mfld_out_if
// Result channel: valid/ready with status and read data.
// ----------------------------------------------------------------------------
interface mfld_out_if import mfld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

// File: design/mfld_cfg_if.sv
// ----------------------------------------------------------------------------
// mfld_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface mfld_cfg_if import mfld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/mfld_ram.sv
// ----------------------------------------------------------------------------
// mfld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mono_framebuffer_line_drawer.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer
// Page-organised 1bpp framebuffer with Bresenham line draw, fill and byte read.
// ----------------------------------------------------------------------------
// One request is in work at a time; the next is taken while a finished result
// still sits in the output register. A line is drawn one pixel per cycle
// through the frame store's single read and write port, the read of a pixel
// overlapping the write of the one before, with forwarding when both fall in
// the same byte. A fill writes W*H/8 bytes, one byte per cycle. After reset
// the store of MAX_COLUMNS*MAX_ROWS/8 bytes (1024 by default) is swept to
// zero, one byte per cycle, and no request is taken until that pass ends;
// configuration writes are taken at any time.
module mono_framebuffer_line_drawer import mfld_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  mfld_in_if.sink   in_ch,
  mfld_out_if.source out_ch,
  mfld_cfg_if.sink  cfg_ch
);

  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS / 8;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > BIDX_W) ? CNT_W : BIDX_W;

  state_t state_r, state_nxt;

  logic [PW_W-1:0] panel_width_r;
  logic [PH_W-1:0] panel_height_r;

  logic [X_W-1:0]   x_cur_r, x_cur_nxt, x_end_r, x_end_nxt;
  logic [Y_W-1:0]   y_cur_r, y_cur_nxt, y_end_r, y_end_nxt;
  logic [X_W-1:0]   dx_r, dx_nxt;
  logic [Y_W-1:0]   dy_r, dy_nxt;
  logic             sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic             on_r, on_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_fwd_r, s1_fwd_nxt;
  logic [AW-1:0]    s1_addr_r, s1_addr_nxt;
  logic [DATA_W-1:0] s1_mask_r, s1_mask_nxt;
  logic [DATA_W-1:0] wdata_last_r, wdata_last_nxt;

  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;

  logic             res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Effective panel geometry
  logic [PW_W-1:0]      w_eff;
  logic [PH_W-1:0]      h_floor, h_eff;
  logic [CNT_W-1:0]     bytes_used;
  logic                 in_acc, cfg_acc, out_free;
  cmd_t                 cmd;
  logic                 draw_ok, read_ok, line_last, fill_done;
  logic [AW-1:0]        line_addr;
  logic [DATA_W-1:0]    merged, rmw_base;
  logic signed [ERR_W:0] e2, ndy, dxs;
  logic                 step_x, step_y;
  logic [X_W-1:0]       dx_in;
  logic [Y_W-1:0]       dy_in;

  always_comb begin
    w_eff = ({1'b0, panel_width_r} > (PW_W + 1)'(MAX_COLUMNS)) ? PW_W'(MAX_COLUMNS)
                                                               : panel_width_r;
    h_floor = {panel_height_r[PH_W-1:PAGE_BITS], PAGE_BITS'(0)};
    h_eff   = ({1'b0, h_floor} > (PH_W + 1)'(MAX_ROWS)) ? PH_W'(MAX_ROWS) : h_floor;
    bytes_used = CNT_W'(PIX_ADDR_W'(w_eff) * PIX_ADDR_W'(h_eff[PH_W-1:PAGE_BITS]));
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_data_r;

  assign cmd = cmd_t'(in_ch.command);
  assign draw_ok = ({1'b0, in_ch.x_start} < (X_W + 1)'(w_eff)) &&
                   ({1'b0, in_ch.x_end}   < (X_W + 1)'(w_eff)) &&
                   ({1'b0, in_ch.y_start} < (Y_W + 1)'(h_eff)) &&
                   ({1'b0, in_ch.y_end}   < (Y_W + 1)'(h_eff));
  assign read_ok = CMP_W'(in_ch.byte_index) < CMP_W'(bytes_used);

  assign line_last = (x_cur_r == x_end_r) && (y_cur_r == y_end_r);
  assign fill_done = (fill_cnt_r >= bytes_used);
  assign line_addr = AW'(pix_addr(x_cur_r, y_cur_r, w_eff));

  assign dx_in = (in_ch.x_end > in_ch.x_start) ? in_ch.x_end - in_ch.x_start
                                               : in_ch.x_start - in_ch.x_end;
  assign dy_in = (in_ch.y_end > in_ch.y_start) ? in_ch.y_end - in_ch.y_start
                                               : in_ch.y_start - in_ch.y_end;

  // Bresenham step
  always_comb begin
    e2     = {err_r, 1'b0};
    ndy    = -$signed((ERR_W + 1)'(dy_r));
    dxs    = $signed((ERR_W + 1)'(dx_r));
    step_x = (e2 > ndy);
    step_y = (e2 < dxs);
  end

  // Read-modify-write merge, forwarding the byte written last cycle
  assign rmw_base = s1_fwd_r ? wdata_last_r : ram_rdata;
  assign merged   = on_r ? (rmw_base | s1_mask_r) : (rmw_base & ~s1_mask_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_DRAW_LINE: state_nxt = draw_ok ? ST_LINE : ST_RESP;
            CMD_FILL:      state_nxt = ST_FILL;
            CMD_READ_BYTE: state_nxt = read_ok ? ST_RD_WAIT : ST_RESP;
            default:       state_nxt = ST_RESP;
          endcase
        end
      end
      ST_LINE: begin
        if (line_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:   state_nxt = ST_RESP;
      ST_FILL: begin
        if (fill_done) state_nxt = ST_RESP;
      end
      ST_RD_WAIT: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = merged;
    ram_raddr = line_addr;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = BYTE_ZEROS;
      end
      ST_IDLE: begin
        ram_raddr = AW'(in_ch.byte_index);
      end
      ST_LINE, ST_DRAIN: begin
        ram_we = s1_valid_r;
      end
      ST_FILL: begin
        ram_we    = !fill_done;
        ram_waddr = AW'(fill_cnt_r);
        ram_wdata = on_r ? BYTE_ONES : BYTE_ZEROS;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    x_cur_nxt      = x_cur_r;
    y_cur_nxt      = y_cur_r;
    x_end_nxt      = x_end_r;
    y_end_nxt      = y_end_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    sx_neg_nxt     = sx_neg_r;
    sy_neg_nxt     = sy_neg_r;
    err_nxt        = err_r;
    on_nxt         = on_r;
    s1_valid_nxt   = 1'b0;
    s1_fwd_nxt     = 1'b0;
    s1_addr_nxt    = s1_addr_r;
    s1_mask_nxt    = s1_mask_r;
    wdata_last_nxt = wdata_last_r;
    clr_addr_nxt   = clr_addr_r;
    fill_cnt_nxt   = fill_cnt_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        on_nxt         = in_ch.pixel_on;
        x_cur_nxt      = in_ch.x_start;
        y_cur_nxt      = in_ch.y_start;
        x_end_nxt      = in_ch.x_end;
        y_end_nxt      = in_ch.y_end;
        dx_nxt         = dx_in;
        dy_nxt         = dy_in;
        sx_neg_nxt     = !(in_ch.x_start < in_ch.x_end);
        sy_neg_nxt     = !(in_ch.y_start < in_ch.y_end);
        err_nxt        = $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));
        fill_cnt_nxt   = '0;
        res_data_nxt   = BYTE_ZEROS;
        res_status_nxt = STATUS_OK;
        if (in_acc) begin
          unique case (cmd)
            CMD_DRAW_LINE: res_status_nxt = draw_ok ? STATUS_OK : STATUS_RANGE;
            CMD_FILL:      res_status_nxt = STATUS_OK;
            CMD_READ_BYTE: res_status_nxt = read_ok ? STATUS_OK : STATUS_RANGE;
            default:       res_status_nxt = STATUS_RANGE;
          endcase
        end
      end
      ST_LINE: begin
        s1_valid_nxt = 1'b1;
        s1_fwd_nxt   = s1_valid_r && (line_addr == s1_addr_r);
        s1_addr_nxt  = line_addr;
        s1_mask_nxt  = pix_mask(y_cur_r);
        if (s1_valid_r) wdata_last_nxt = merged;
        if (!line_last) begin
          err_nxt = err_r - (step_x ? $signed(ERR_W'(dy_r)) : '0)
                          + (step_y ? $signed(ERR_W'(dx_r)) : '0);
          if (step_x) x_cur_nxt = sx_neg_r ? x_cur_r - X_W'(1) : x_cur_r + X_W'(1);
          if (step_y) y_cur_nxt = sy_neg_r ? y_cur_r - Y_W'(1) : y_cur_r + Y_W'(1);
        end
      end
      ST_DRAIN: begin
        if (s1_valid_r) wdata_last_nxt = merged;
      end
      ST_FILL: begin
        if (!fill_done) fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
      end
      ST_RD_WAIT: begin
        res_data_nxt = ram_rdata;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
        end
      end
      default: begin
        s1_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      panel_width_r  <= PANEL_WIDTH_RESET;
      panel_height_r <= PANEL_HEIGHT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        if (cfg_ch.index == REG_PANEL_WIDTH) begin
          panel_width_r <= cfg_ch.data[PW_W-1:0];
        end else begin
          panel_height_r <= cfg_ch.data[PH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    x_cur_r      <= x_cur_nxt;
    y_cur_r      <= y_cur_nxt;
    x_end_r      <= x_end_nxt;
    y_end_r      <= y_end_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    sx_neg_r     <= sx_neg_nxt;
    sy_neg_r     <= sy_neg_nxt;
    err_r        <= err_nxt;
    on_r         <= on_nxt;
    s1_fwd_r     <= s1_fwd_nxt;
    s1_addr_r    <= s1_addr_nxt;
    s1_mask_r    <= s1_mask_nxt;
    wdata_last_r <= wdata_last_nxt;
    fill_cnt_r   <= fill_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  mfld_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
